@@ rtl/bba_pkg.sv @@
// Shared types and codes for the buddy block allocator.
package bba_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_TOO_BIG   = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_BAD_FREE  = 3'd4
    } status_t;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } func_t;

    typedef struct packed {
        logic       start;
        logic       free;
        logic [4:0] order;
    } tag_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHECK,
        S_A_READ,
        S_A_EVAL,
        S_A_SPLIT,
        S_A_MARK,
        S_F_CHECK,
        S_F_READ,
        S_F_EVAL,
        S_M_CHECK,
        S_M_EVAL,
        S_F_MARK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic cap_in;
        logic clr_start;
        logic clr_step;
        logic a_check;
        logic scan_rd;
        logic scan_eval;
        logic split_step;
        logic a_mark;
        logic f_check;
        logic f_rd;
        logic f_eval;
        logic m_rd;
        logic m_eval;
        logic f_mark;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic a_err;
        logic scan_last;
        logic scan_found;
        logic split_done;
        logic f_bad;
        logic tag_bad;
        logic merge_more;
        logic buddy_ok;
        logic out_busy;
    } stat_t;

    localparam int REG_POOL_LOG = 0;

endpackage

@@ rtl/buddy_block_allocator_top.sv @@
// Buddy block allocator top level: APB register, controller and datapath.
// Alloc: size check, then a walk that reads and evaluates each block tag in turn, then
// splits down to the needed order and the mark; size errors and no space end earlier.
// Free: address and tag checks, then buddy checks and merges; a bad free ends at a check.
// One item in work at a time; the next transfer is taken in idle, after the result loads.
// Reset and every pool_log write clear the 2^(pool_log-MIN_ORDER) used tags, no input.
module buddy_block_allocator_top #(
    parameter int MAX_POOL_LOG = 16,
    parameter int MIN_ORDER    = 5,
    parameter int HEADER_BYTES = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_bytes[15:0], free_addr[31:16]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // addr[15:0], block_order[20:16], zero pad
    output logic [2:0]  m_tuser    // status
);

    logic [4:0]     pool_log_reg;
    logic [4:0]     plog;
    logic           cfg_wr;
    bba_pkg::cmd_t  cmd;
    bba_pkg::stat_t st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr == 3'(4 * bba_pkg::REG_POOL_LOG));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_log_reg <= 5'd16;
        end else if (cfg_wr) begin
            pool_log_reg <= pwdata[4:0];
        end
    end

    assign prdata = (paddr == 3'(4 * bba_pkg::REG_POOL_LOG)) ? {27'd0, pool_log_reg} : '0;

    assign plog = (pool_log_reg < 5'(MIN_ORDER))    ? 5'(MIN_ORDER) :
                  (pool_log_reg > 5'(MAX_POOL_LOG)) ? 5'(MAX_POOL_LOG) : pool_log_reg;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bba_dp #(
        .MAX_POOL_LOG (MAX_POOL_LOG),
        .MIN_ORDER    (MIN_ORDER),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .plog     (plog),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

@@ rtl/bba_ctrl.sv @@
// Sequencing state machine for the buddy block allocator.
module bba_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr,
    input  logic           s_tvalid,
    input  logic           s_tuser,
    output logic           s_tready,
    input  bba_pkg::stat_t st,
    output bba_pkg::cmd_t  cmd
);

    bba_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bba_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::S_CLEAR:   if (st.clr_last) state_next = bba_pkg::S_IDLE;
            bba_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == bba_pkg::FN_FREE) ? bba_pkg::S_F_CHECK
                                                               : bba_pkg::S_A_CHECK;
                end
            end
            bba_pkg::S_A_CHECK: state_next = st.a_err ? bba_pkg::S_DONE : bba_pkg::S_A_READ;
            bba_pkg::S_A_READ:  state_next = bba_pkg::S_A_EVAL;
            bba_pkg::S_A_EVAL: begin
                if (st.scan_last) begin
                    state_next = st.scan_found ? bba_pkg::S_A_SPLIT : bba_pkg::S_DONE;
                end else begin
                    state_next = bba_pkg::S_A_READ;
                end
            end
            bba_pkg::S_A_SPLIT: if (st.split_done) state_next = bba_pkg::S_A_MARK;
            bba_pkg::S_A_MARK:  state_next = bba_pkg::S_DONE;
            bba_pkg::S_F_CHECK: state_next = st.f_bad ? bba_pkg::S_DONE : bba_pkg::S_F_READ;
            bba_pkg::S_F_READ:  state_next = bba_pkg::S_F_EVAL;
            bba_pkg::S_F_EVAL:  state_next = st.tag_bad ? bba_pkg::S_DONE : bba_pkg::S_M_CHECK;
            bba_pkg::S_M_CHECK: state_next = st.merge_more ? bba_pkg::S_M_EVAL
                                                           : bba_pkg::S_F_MARK;
            bba_pkg::S_M_EVAL:  state_next = st.buddy_ok ? bba_pkg::S_M_CHECK
                                                         : bba_pkg::S_F_MARK;
            bba_pkg::S_F_MARK:  state_next = bba_pkg::S_DONE;
            bba_pkg::S_DONE:    if (!st.out_busy) state_next = bba_pkg::S_IDLE;
            default:            state_next = bba_pkg::S_CLEAR;
        endcase
        if (cfg_wr) state_next = bba_pkg::S_CLEAR;
    end

    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            bba_pkg::S_CLEAR:   cmd.clr_step = 1'b1;
            bba_pkg::S_IDLE: begin
                s_tready   = 1'b1;
                cmd.cap_in = s_tvalid;
            end
            bba_pkg::S_A_CHECK: cmd.a_check = 1'b1;
            bba_pkg::S_A_READ:  cmd.scan_rd = 1'b1;
            bba_pkg::S_A_EVAL:  cmd.scan_eval = 1'b1;
            bba_pkg::S_A_SPLIT: cmd.split_step = !st.split_done;
            bba_pkg::S_A_MARK:  cmd.a_mark = 1'b1;
            bba_pkg::S_F_CHECK: cmd.f_check = 1'b1;
            bba_pkg::S_F_READ:  cmd.f_rd = 1'b1;
            bba_pkg::S_F_EVAL:  cmd.f_eval = 1'b1;
            bba_pkg::S_M_CHECK: cmd.m_rd = st.merge_more;
            bba_pkg::S_M_EVAL:  cmd.m_eval = 1'b1;
            bba_pkg::S_F_MARK:  cmd.f_mark = 1'b1;
            bba_pkg::S_DONE:    cmd.out_load = !st.out_busy;
            default:            cmd = '0;
        endcase
        if (cfg_wr) begin
            cmd.clr_start = 1'b1;
            cmd.clr_step  = 1'b0;
        end
    end

endmodule

@@ rtl/bba_dp.sv @@
// Datapath of the buddy block allocator: tag memory, scan, split, merge, result register.
module bba_dp #(
    parameter int MAX_POOL_LOG = 16,
    parameter int MIN_ORDER    = 5,
    parameter int HEADER_BYTES = 24
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [4:0]     plog,
    input  bba_pkg::cmd_t  cmd,
    output bba_pkg::stat_t st,
    input  logic [31:0]    s_tdata,
    output logic [23:0]    m_tdata,
    output logic [2:0]     m_tuser,
    output logic           m_tvalid,
    input  logic           m_tready
);

    localparam int UW    = MAX_POOL_LOG - MIN_ORDER;
    localparam int UW1   = UW + 1;
    localparam int DEPTH = 1 << UW;
    localparam int AW    = (MAX_POOL_LOG + 1 > 17) ? MAX_POOL_LOG + 1 : 17;

    bba_pkg::tag_t mem [DEPTH];
    bba_pkg::tag_t rd_q_reg;

    logic [15:0]  req_reg, faddr_reg;
    logic [UW-1:0] u_reg, best_u_reg;
    logic         found_reg;
    logic [4:0]   best_ord_reg, k_reg, ord_reg;
    logic [UW:0]  clr_cnt_reg;
    logic [2:0]   res_st_reg, out_st_reg;
    logic [15:0]  res_addr_reg, out_addr_reg;
    logic [4:0]   res_ord_reg, out_ord_reg;
    logic         m_valid_reg;

    logic [UW:0]   n_units;
    logic [AW-1:0] pool_bytes, total, off_w;
    logic [4:0]    k_calc;
    logic [UW:0]   scan_step, scan_nxt, split_s, ord_s;
    logic          cand;
    logic [4:0]    best_m1;
    logic [UW-1:0] bu, lo, hi, split_a;
    logic [15:0]   off;
    logic [AW-1:0] alloc_addr;

    logic          we;
    logic [UW-1:0] wa, ra;
    bba_pkg::tag_t wd;

    assign n_units    = UW1'(1) << (plog - 5'(MIN_ORDER));
    assign pool_bytes = AW'(1) << plog;
    assign total      = AW'(req_reg) + AW'(HEADER_BYTES);
    assign off        = faddr_reg - 16'(HEADER_BYTES);
    assign off_w      = AW'(off);

    always_comb begin
        k_calc = 5'(MIN_ORDER);
        for (int i = 0; i < AW; i++) begin
            if (total > (AW'(1) << i) && 5'(i + 1) > k_calc) k_calc = 5'(i + 1);
        end
    end

    assign scan_step = rd_q_reg.start ? (UW1'(1) << (rd_q_reg.order - 5'(MIN_ORDER)))
                                      : UW1'(1);
    assign scan_nxt  = UW1'(u_reg) + scan_step;
    assign cand      = rd_q_reg.start && rd_q_reg.free && rd_q_reg.order >= k_reg &&
                       (!found_reg || rd_q_reg.order < best_ord_reg);
    assign best_m1   = best_ord_reg - 5'd1;
    assign split_s   = UW1'(1) << (best_m1 - 5'(MIN_ORDER));
    assign split_a   = UW'(UW1'(best_u_reg) + split_s);
    assign ord_s     = UW1'(1) << (ord_reg - 5'(MIN_ORDER));
    assign bu        = u_reg ^ ord_s[UW-1:0];
    assign lo        = u_reg & ~ord_s[UW-1:0];
    assign hi        = u_reg | ord_s[UW-1:0];
    assign alloc_addr = (AW'(best_u_reg) << MIN_ORDER) + AW'(HEADER_BYTES);

    always_comb begin
        st.clr_last   = (clr_cnt_reg + UW1'(1)) >= n_units;
        st.a_err      = (req_reg == 16'd0) || (total > pool_bytes);
        st.scan_last  = scan_nxt >= n_units;
        st.scan_found = found_reg || cand;
        st.split_done = best_ord_reg <= k_reg;
        st.f_bad      = (faddr_reg < 16'(HEADER_BYTES)) || (off_w >= pool_bytes) ||
                        (off[MIN_ORDER-1:0] != '0);
        st.tag_bad    = !rd_q_reg.start || rd_q_reg.free;
        st.merge_more = (ord_reg < plog) && (ord_reg >= 5'(MIN_ORDER));
        st.buddy_ok   = rd_q_reg.start && rd_q_reg.free && (rd_q_reg.order == ord_reg);
        st.out_busy   = m_valid_reg && !m_tready;
    end

    always_comb begin
        we = 1'b0;
        wa = u_reg;
        wd = '0;
        ra = cmd.m_rd ? bu : u_reg;
        if (cmd.clr_step) begin
            we = 1'b1;
            wa = clr_cnt_reg[UW-1:0];
            wd = (clr_cnt_reg == '0) ? '{start: 1'b1, free: 1'b1, order: plog} : '0;
        end else if (cmd.split_step) begin
            we = 1'b1;
            wa = split_a;
            wd = '{start: 1'b1, free: 1'b1, order: best_m1};
        end else if (cmd.a_mark) begin
            we = 1'b1;
            wa = best_u_reg;
            wd = '{start: 1'b1, free: 1'b0, order: best_ord_reg};
        end else if (cmd.m_eval && st.buddy_ok) begin
            we = 1'b1;
            wa = hi;
            wd = '0;
        end else if (cmd.f_mark) begin
            we = 1'b1;
            wa = u_reg;
            wd = '{start: 1'b1, free: 1'b1, order: ord_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        rd_q_reg <= mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_start) begin
                clr_cnt_reg <= '0;
            end else if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + UW1'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            req_reg   <= s_tdata[15:0];
            faddr_reg <= s_tdata[31:16];
            u_reg     <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.a_check) begin
            k_reg <= k_calc;
            if (st.a_err) begin
                res_st_reg   <= (req_reg == 16'd0) ? bba_pkg::ST_ZERO_SIZE
                                                   : bba_pkg::ST_TOO_BIG;
                res_addr_reg <= '0;
                res_ord_reg  <= '0;
            end
        end
        if (cmd.scan_eval) begin
            u_reg <= scan_nxt[UW-1:0];
            if (cand) begin
                found_reg    <= 1'b1;
                best_u_reg   <= u_reg;
                best_ord_reg <= rd_q_reg.order;
            end
            if (st.scan_last && !st.scan_found) begin
                res_st_reg   <= bba_pkg::ST_NO_SPACE;
                res_addr_reg <= '0;
                res_ord_reg  <= '0;
            end
        end
        if (cmd.split_step) best_ord_reg <= best_m1;
        if (cmd.a_mark) begin
            res_st_reg   <= bba_pkg::ST_OK;
            res_addr_reg <= alloc_addr[15:0];
            res_ord_reg  <= best_ord_reg;
        end
        if (cmd.f_check) begin
            u_reg <= off_w[MIN_ORDER +: UW];
            if (st.f_bad) begin
                res_st_reg   <= bba_pkg::ST_BAD_FREE;
                res_addr_reg <= '0;
                res_ord_reg  <= '0;
            end
        end
        if (cmd.f_eval) begin
            ord_reg <= rd_q_reg.order;
            if (st.tag_bad) begin
                res_st_reg   <= bba_pkg::ST_BAD_FREE;
                res_addr_reg <= '0;
                res_ord_reg  <= '0;
            end
        end
        if (cmd.m_eval && st.buddy_ok) begin
            u_reg   <= lo;
            ord_reg <= ord_reg + 5'd1;
        end
        if (cmd.f_mark) begin
            res_st_reg   <= bba_pkg::ST_OK;
            res_addr_reg <= faddr_reg;
            res_ord_reg  <= ord_reg;
        end
        if (cmd.out_load) begin
            out_st_reg   <= res_st_reg;
            out_addr_reg <= res_addr_reg;
            out_ord_reg  <= res_ord_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_st_reg;
    assign m_tdata  = {3'b000, out_ord_reg, out_addr_reg};

endmodule
